/* rtl/aradi_block_cipher_unit_defines.svh */
// Assertion macros for the cipher unit checker
`ifndef ARADI_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define ARADI_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define ARD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ARD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/ard_pkg.sv */
// Shared types, constants and round functions for the cipher unit
package ard_pkg;
   localparam int ROUND_COUNT_DEFAULT = 16;
   localparam int KEY_REG_COUNT = 4;
   localparam logic [1:0] CSR_KEY_01 = 2'd0;
   localparam logic [1:0] CSR_KEY_23 = 2'd1;
   localparam logic [1:0] CSR_KEY_45 = 2'd2;
   localparam logic [1:0] CSR_KEY_67 = 2'd3;
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef logic [31:0] word_type;
   typedef word_type [3:0] state_type;
   typedef word_type [7:0] key_type;

   typedef struct packed {
      logic     valid;
      logic     cmd;
      state_type blk;
   } stage_type;

   function automatic logic [15:0] rol16(input logic [15:0] v, input int r);
      rol16 = (v << r) | (v >> ((16 - r) % 16));
   endfunction

   function automatic word_type rol32(input word_type v, input int r);
      rol32 = (v << r) | (v >> ((32 - r) % 32));
   endfunction

   function automatic word_type lin_map(input logic [1:0] sel, input word_type v);
      logic [15:0] hi;
      logic [15:0] lo;
      logic [15:0] nhi;
      logic [15:0] nlo;
      hi = v[31:16];
      lo = v[15:0];
      unique case (sel)
         2'd0: begin
            nhi = hi ^ rol16(hi, 11) ^ rol16(lo, 14);
            nlo = lo ^ rol16(lo, 11) ^ rol16(hi, 8);
         end
         2'd1: begin
            nhi = hi ^ rol16(hi, 10) ^ rol16(lo, 11);
            nlo = lo ^ rol16(lo, 10) ^ rol16(hi, 9);
         end
         2'd2: begin
            nhi = hi ^ rol16(hi, 9) ^ rol16(lo, 14);
            nlo = lo ^ rol16(lo, 9) ^ rol16(hi, 4);
         end
         default: begin
            nhi = hi ^ rol16(hi, 8) ^ rol16(lo, 7);
            nlo = lo ^ rol16(lo, 8) ^ rol16(hi, 9);
         end
      endcase
      lin_map = {nhi, nlo};
   endfunction

   function automatic key_type key_advance(input key_type k, input int n);
      key_type t;
      key_type o;
      t[0] = rol32(k[0], 1) ^ k[1];
      t[1] = rol32(k[1], 3) ^ t[0];
      t[2] = rol32(k[2], 9) ^ k[3];
      t[3] = rol32(k[3], 28) ^ t[2];
      t[4] = rol32(k[4], 1) ^ k[5];
      t[5] = rol32(k[5], 3) ^ t[4];
      t[6] = rol32(k[6], 9) ^ k[7];
      t[7] = rol32(k[7], 28) ^ t[6];
      if (n % 2 == 0) begin
         o = '{t[7] ^ word_type'(n), t[5], t[6], t[4], t[3], t[1], t[2], t[0]};
      end else begin
         o = '{t[7] ^ word_type'(n), t[3], t[5], t[1], t[6], t[2], t[4], t[0]};
      end
      key_advance = o;
   endfunction

   function automatic state_type enc_round(input state_type s, input state_type rk,
                                           input logic [1:0] sel);
      state_type x;
      x = s ^ rk;
      x[1] ^= x[0] & x[2];
      x[3] ^= x[1] & x[2];
      x[2] ^= x[0] & x[3];
      x[0] ^= x[1] & x[3];
      for (int j = 0; j < 4; j++) x[j] = lin_map(sel, x[j]);
      enc_round = x;
   endfunction

   function automatic state_type dec_round(input state_type s, input state_type rk,
                                           input logic [1:0] sel);
      state_type x;
      for (int j = 0; j < 4; j++) x[j] = lin_map(sel, s[j]);
      x[0] ^= x[1] & x[3];
      x[2] ^= x[0] & x[3];
      x[3] ^= x[1] & x[2];
      x[1] ^= x[0] & x[2];
      dec_round = x ^ rk;
   endfunction
endpackage

/* rtl/ard_key_sched.sv */
// Round key table, rebuilt into registers whenever a key word is written
module ard_key_sched #(
   parameter int ROUND_COUNT = ard_pkg::ROUND_COUNT_DEFAULT
) (
   input  logic                clock,
   input  ard_pkg::key_type    key,
   output ard_pkg::state_type  rk [ROUND_COUNT+1]
);
   import ard_pkg::*;
   key_type kc [ROUND_COUNT+1];
   state_type rk_in [ROUND_COUNT+1];

   // key expansion is a chain of short rotate-xor steps; register every round key
   always_comb begin
      kc[0] = key;
      for (int n = 1; n <= ROUND_COUNT; n++) kc[n] = key_advance(kc[n-1], n - 1);
      for (int n = 0; n <= ROUND_COUNT; n++) begin
         rk_in[n] = (n % 2 == 1) ? state_type'(kc[n][7:4]) : state_type'(kc[n][3:0]);
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n <= ROUND_COUNT; n++) rk[n] <= rk_in[n];
   end
endmodule

/* rtl/ard_datapath.sv */
// Single-pass encrypt/decrypt datapath between input and result registers
module ard_datapath #(
   parameter int ROUND_COUNT = ard_pkg::ROUND_COUNT_DEFAULT
) (
   input  ard_pkg::stage_type  src,
   input  ard_pkg::state_type  rk [ROUND_COUNT+1],
   output ard_pkg::state_type  dst
);
   import ard_pkg::*;
   state_type enc [ROUND_COUNT+1];
   state_type dec [ROUND_COUNT+1];

   always_comb begin
      enc[0] = src.blk;
      for (int r = 0; r < ROUND_COUNT; r++) begin
         enc[r+1] = enc_round(enc[r], rk[r], 2'(r));
      end
      dec[ROUND_COUNT] = src.blk ^ rk[ROUND_COUNT];
      for (int r = ROUND_COUNT; r > 0; r--) begin
         dec[r-1] = dec_round(dec[r], rk[r-1], 2'(r - 1));
      end
      dst = (src.cmd == CMD_DECRYPT) ? dec[0] : (enc[ROUND_COUNT] ^ rk[ROUND_COUNT]);
   end
endmodule

/* rtl/aradi_block_cipher_unit.sv */
// Top level of the block cipher unit: key registers, stream handshake, datapath
// Usage:
//   Write the 256-bit key over the csr_ port as four 64-bit words (byte
//   addresses 0, 8, 16, 24) while the unit is idle, then allow one cycle for
//   the round key registers to settle before streaming blocks.
//   req_ carries one block and a command bit per transfer; rsp_ returns the
//   encrypted or decrypted block.
//   Path: a block taken on req_ passes the input register, then the result
//   register, before rsp_tvalid. Throughput: one block per cycle while
//   rsp_tready is high, set by the all-rounds datapath between the two registers.
//   Stall: while rsp_tready is low the result holds; the input register
//   keeps accepting as long as the result register can drain or is empty.
//   Reset clears the key words and all valid flags; no clearing pass.
module aradi_block_cipher_unit #(
   parameter int ROUND_COUNT = ard_pkg::ROUND_COUNT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_lo[63:0], block_hi[127:64]
   input  logic         req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // result_lo[63:0], result_hi[127:64]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import ard_pkg::*;
   logic [63:0] key_ff [KEY_REG_COUNT];
   key_type     key;
   state_type   rk [ROUND_COUNT+1];
   stage_type   in_ff;
   stage_type   in_in;
   logic        out_valid_ff;
   state_type   out_ff;
   state_type   dst;
   logic        out_free;
   logic        in_free;
   logic [1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_REG_COUNT; i++) key_ff[i] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         key_ff[csr_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_KEY_01: csr_prdata = key_ff[0];
         CSR_KEY_23: csr_prdata = key_ff[1];
         CSR_KEY_45: csr_prdata = key_ff[2];
         default:    csr_prdata = key_ff[3];
      endcase
   end

   assign key = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};

   ard_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_sched (
      .clock (clock),
      .key   (key),
      .rk    (rk)
   );

   ard_datapath #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
      .src (in_ff),
      .rk  (rk),
      .dst (dst)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_free    = !in_ff.valid || out_free;
   assign req_tready = in_free;

   always_comb begin
      in_in = in_ff;
      if (in_free) begin
         in_in.valid = req_tvalid;
         in_in.cmd   = req_tuser;
         in_in.blk   = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_ff.valid <= in_in.valid;
         if (out_free) out_valid_ff <= in_ff.valid;
      end
      in_ff.cmd <= in_in.cmd;
      in_ff.blk <= in_in.blk;
      if (out_free && in_ff.valid) out_ff <= dst;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
endmodule

/* rtl/ard_checker.sv */
// Port-level checker for the cipher unit, bound to the top level
`include "aradi_block_cipher_unit_defines.svh"
module ard_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         csr_pready
);
   `ARD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ARD_ASSERT_IMPL(a_ready_drain, clock, reset, rsp_tready, req_tready)
   `ARD_ASSERT_NEXT(a_req_yields_rsp, clock, reset, req_tvalid && req_tready, ##1 rsp_tvalid)
   `ARD_ASSERT_IMPL(a_pready, clock, reset, 1'b1, csr_pready)
endmodule

bind aradi_block_cipher_unit ard_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
